>>> design/yuv420_block_to_rgba_top_defines.svh
// Assertion macros shared by the checker of the YCbCr 4:2:0 to RGBA converter.
`ifndef YUV420_BLOCK_TO_RGBA_TOP_DEFINES_SVH
`define YUV420_BLOCK_TO_RGBA_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define YRGB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define YRGB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/yrgb_pkg.sv
// Shared types and constants for the YCbCr 4:2:0 to RGBA converter.
package yrgb_pkg;

  localparam int unsigned NumLanes = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LUMA_OFFSET   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LUMA_GAIN     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RED_CR_GAIN   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BLUE_CB_GAIN  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GREEN_CB_GAIN = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_GREEN_CR_GAIN = 3'd5;

  // Chroma terms shared by all lanes, 16-bit two's complement
  typedef struct packed {
    logic signed [15:0] rc;
    logic signed [15:0] gc;
    logic signed [15:0] bc;
  } chroma_terms_t;

  // Clamp a 16-bit signed value to 0..255
  function automatic logic [7:0] sat8(input logic signed [15:0] v);
    logic [7:0] res;
    if (v[15]) begin
      res = 8'd0;
    end else if (v[14:8] != 7'd0) begin
      res = 8'hFF;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

>>> design/yuv420_block_to_rgba_top.sv
// Top level of the YCbCr 4:2:0 2x2 block to packed RGBA converter.
// Four luma lanes and one chroma unit run in parallel, product stage then output register.
// Throughput: one 2x2 block per cycle while the output is not stalled.
// Input ready drops only when both the product stage and the output register are full
// and the output is stalled. Reset clears the valid bits and loads the default gains;
// pipeline payload registers are not reset.
module yuv420_block_to_rgba_top import yrgb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          luma_top_left_i,
  input  logic [7:0]          luma_top_right_i,
  input  logic [7:0]          luma_bottom_left_i,
  input  logic [7:0]          luma_bottom_right_i,
  input  logic [7:0]          chroma_blue_i,
  input  logic [7:0]          chroma_red_i,
  input  logic [7:0]          alpha_top_left_i,
  input  logic [7:0]          alpha_top_right_i,
  input  logic [7:0]          alpha_bottom_left_i,
  input  logic [7:0]          alpha_bottom_right_i,
  input  logic                alpha_present_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         pixel_top_left_o,
  output logic [31:0]         pixel_top_right_o,
  output logic [31:0]         pixel_bottom_left_o,
  output logic [31:0]         pixel_bottom_right_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must only land while the pipe is idle; the block
  // itself does not enforce this. The product stage reads them directly.
  // ---------------------------------------------------------------------------
  logic [7:0]  luma_offset_q;
  logic [15:0] luma_gain_q, red_cr_gain_q, blue_cb_gain_q;
  logic [15:0] green_cb_gain_q, green_cr_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_offset_q   <= 8'd16;
      luma_gain_q     <= 16'd149;
      red_cr_gain_q   <= 16'd102;
      blue_cb_gain_q  <= 16'd129;
      green_cb_gain_q <= 16'd50;
      green_cr_gain_q <= 16'd104;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LUMA_OFFSET:   luma_offset_q   <= cfg_data_i[7:0];
        CFG_LUMA_GAIN:     luma_gain_q     <= cfg_data_i;
        CFG_RED_CR_GAIN:   red_cr_gain_q   <= cfg_data_i;
        CFG_BLUE_CB_GAIN:  blue_cb_gain_q  <= cfg_data_i;
        CFG_GREEN_CB_GAIN: green_cb_gain_q <= cfg_data_i;
        CFG_GREEN_CR_GAIN: green_cr_gain_q <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake / pipeline control.
  // Stage 1 holds the products, stage 2 is the output register. Stage 1
  // drains whenever the output register is empty or being read.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_adv, in_fire;

  assign out_adv    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (out_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  assign out_valid_d = out_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: chroma products once per block, luma product per lane.
  // Alpha is resolved here and travels alongside.
  // ---------------------------------------------------------------------------
  logic [7:0]    luma     [NumLanes];
  logic [7:0]    alpha_in [NumLanes];
  logic [7:0]    alpha_q  [NumLanes];
  logic [23:0]   rgb      [NumLanes];
  chroma_terms_t terms;

  assign luma[0] = luma_top_left_i;
  assign luma[1] = luma_top_right_i;
  assign luma[2] = luma_bottom_left_i;
  assign luma[3] = luma_bottom_right_i;

  assign alpha_in[0] = alpha_present_i ? alpha_top_left_i     : 8'hFF;
  assign alpha_in[1] = alpha_present_i ? alpha_top_right_i    : 8'hFF;
  assign alpha_in[2] = alpha_present_i ? alpha_bottom_left_i  : 8'hFF;
  assign alpha_in[3] = alpha_present_i ? alpha_bottom_right_i : 8'hFF;

  yrgb_chroma u_chroma (
    .clk_i           (clk_i),
    .en_i            (in_fire),
    .cb_i            (chroma_blue_i),
    .cr_i            (chroma_red_i),
    .red_cr_gain_i   (red_cr_gain_q),
    .blue_cb_gain_i  (blue_cb_gain_q),
    .green_cb_gain_i (green_cb_gain_q),
    .green_cr_gain_i (green_cr_gain_q),
    .terms_o         (terms)
  );

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    yrgb_lane u_lane (
      .clk_i         (clk_i),
      .en_i          (in_fire),
      .luma_i        (luma[l]),
      .luma_offset_i (luma_offset_q),
      .luma_gain_i   (luma_gain_q),
      .terms_i       (terms),
      .rgb_o         (rgb[l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int i = 0; i < NumLanes; i++) begin
        alpha_q[i] <= alpha_in[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: merge lane results with alpha into the packed output register.
  // ---------------------------------------------------------------------------
  logic [31:0] pixel_q [NumLanes];

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      for (int i = 0; i < NumLanes; i++) begin
        pixel_q[i] <= {alpha_q[i], rgb[i]};
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign pixel_top_left_o     = pixel_q[0];
  assign pixel_top_right_o    = pixel_q[1];
  assign pixel_bottom_left_o  = pixel_q[2];
  assign pixel_bottom_right_o = pixel_q[3];

endmodule

>>> design/yrgb_chroma.sv
// Shared chroma unit: four gain products registered, then the r/g/b chroma terms.
module yrgb_chroma import yrgb_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [7:0]          cb_i,
  input  logic [7:0]          cr_i,
  input  logic [15:0]         red_cr_gain_i,
  input  logic [15:0]         blue_cb_gain_i,
  input  logic [15:0]         green_cb_gain_i,
  input  logic [15:0]         green_cr_gain_i,
  output chroma_terms_t       terms_o
);

  logic [15:0] cb_c, cr_c;
  logic [31:0] prod_r, prod_b, prod_gcb, prod_gcr;
  logic [15:0] prod_r_q, prod_b_q, prod_gcb_q, prod_gcr_q;
  logic [15:0] gsum;

  // sample - 128, sign extended to 16 bits
  assign cb_c = {{8{~cb_i[7]}}, ~cb_i[7], cb_i[6:0]};
  assign cr_c = {{8{~cr_i[7]}}, ~cr_i[7], cr_i[6:0]};

  // only the low 16 bits survive, so an unsigned multiply suffices
  assign prod_r   = cr_c * red_cr_gain_i;
  assign prod_b   = cb_c * blue_cb_gain_i;
  assign prod_gcb = cb_c * green_cb_gain_i;
  assign prod_gcr = cr_c * green_cr_gain_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_r_q   <= prod_r[15:0];
      prod_b_q   <= prod_b[15:0];
      prod_gcb_q <= prod_gcb[15:0];
      prod_gcr_q <= prod_gcr[15:0];
    end
  end

  assign gsum = prod_gcb_q + prod_gcr_q;

  assign terms_o.rc = $signed(prod_r_q) >>> 6;
  assign terms_o.bc = $signed(prod_b_q) >>> 6;
  assign terms_o.gc = $signed(gsum) >>> 7;

endmodule

>>> design/yrgb_lane.sv
// One pixel lane: black level, registered luma gain product, channel sums and clamp.
module yrgb_lane import yrgb_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [7:0]          luma_i,
  input  logic [7:0]          luma_offset_i,
  input  logic [15:0]         luma_gain_i,
  input  chroma_terms_t       terms_i,
  output logic [23:0]         rgb_o
);

  logic [7:0]         ofs;
  logic [31:0]        prod;
  logic [15:0]        prod_q;
  logic signed [15:0] y, r_sum, g_sum, b_sum;

  // luma below black level clamps to zero
  assign ofs  = (luma_i > luma_offset_i) ? (luma_i - luma_offset_i) : 8'd0;
  assign prod = {8'd0, ofs} * luma_gain_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod[15:0];
    end
  end

  assign y     = $signed(prod_q) >>> 7;
  assign r_sum = y + terms_i.rc;
  assign g_sum = y - terms_i.gc;
  assign b_sum = y + terms_i.bc;

  assign rgb_o = {sat8(b_sum), sat8(g_sum), sat8(r_sum)};

endmodule

>>> design/yrgb_checker.sv
// Port-level checker for the converter top level, attached by bind.
`include "yuv420_block_to_rgba_top_defines.svh"

module yrgb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [31:0]         pixel_top_left_o,
  input logic [31:0]         pixel_top_right_o,
  input logic [31:0]         pixel_bottom_left_o,
  input logic [31:0]         pixel_bottom_right_o
);

  // stalled result holds
  `YRGB_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(pixel_top_left_o) && $stable(pixel_top_right_o) && $stable(pixel_bottom_left_o) && $stable(pixel_bottom_right_o), "stalled result changed")

  // input backpressure only comes from a stalled, full output
  `YRGB_ASSERT_NOW(a_ready_cause, !in_ready_o, out_valid_o && !out_ready_i, "input stalled without output backpressure")

  // an accepted transaction with the output draining moves through the product stage into the output register
  `YRGB_ASSERT_NEXT(a_latency, (in_valid_i && in_ready_o) ##1 out_ready_i, out_valid_o, "result missing after two cycles")

  // with an empty output, the input is always ready
  `YRGB_ASSERT_NOW(a_empty_ready, !out_valid_o, in_ready_o, "input not ready while output empty")

endmodule

bind yuv420_block_to_rgba_top yrgb_checker u_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the 4:2:0 2x2 block to packed RGBA converter.
`timescale 1ns / 1ps

module testbench;
  import yrgb_pkg::*;

  // Register indexes past the end of the map; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED_HI = 3'd7;

  // Register values after reset
  localparam logic [7:0]  LUMA_OFFSET_RST   = 8'd16;
  localparam logic [15:0] LUMA_GAIN_RST     = 16'd149;
  localparam logic [15:0] RED_CR_GAIN_RST   = 16'd102;
  localparam logic [15:0] BLUE_CB_GAIN_RST  = 16'd129;
  localparam logic [15:0] GREEN_CB_GAIN_RST = 16'd50;
  localparam logic [15:0] GREEN_CR_GAIN_RST = 16'd104;

  // Watchdog limit for the whole run of ~570 blocks
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Two pipeline stages between input and output transaction
  localparam int unsigned PIPE_DEPTH = 2;

  // One 2x2 block; lane 0 top left, 1 top right, 2 bottom left, 3 bottom right
  typedef struct packed {
    logic [3:0][7:0] luma;
    logic [7:0]      cb;
    logic [7:0]      cr;
    logic [3:0][7:0] alpha;
    logic            has_alpha;
  } yuv_block_t;

  // Four packed RGBA pixels, same lane order
  typedef struct packed {
    logic [3:0][31:0] pix;
  } rgba_block_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          luma_top_left_i;
  logic [7:0]          luma_top_right_i;
  logic [7:0]          luma_bottom_left_i;
  logic [7:0]          luma_bottom_right_i;
  logic [7:0]          chroma_blue_i;
  logic [7:0]          chroma_red_i;
  logic [7:0]          alpha_top_left_i;
  logic [7:0]          alpha_top_right_i;
  logic [7:0]          alpha_bottom_left_i;
  logic [7:0]          alpha_bottom_right_i;
  logic                alpha_present_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [31:0]         pixel_top_left_o;
  logic [31:0]         pixel_top_right_o;
  logic [31:0]         pixel_bottom_left_o;
  logic [31:0]         pixel_bottom_right_o;

  yuv420_block_to_rgba_top DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .luma_top_left_i      (luma_top_left_i),
    .luma_top_right_i     (luma_top_right_i),
    .luma_bottom_left_i   (luma_bottom_left_i),
    .luma_bottom_right_i  (luma_bottom_right_i),
    .chroma_blue_i        (chroma_blue_i),
    .chroma_red_i         (chroma_red_i),
    .alpha_top_left_i     (alpha_top_left_i),
    .alpha_top_right_i    (alpha_top_right_i),
    .alpha_bottom_left_i  (alpha_bottom_left_i),
    .alpha_bottom_right_i (alpha_bottom_right_i),
    .alpha_present_i      (alpha_present_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .pixel_top_left_o     (pixel_top_left_o),
    .pixel_top_right_o    (pixel_top_right_o),
    .pixel_bottom_left_o  (pixel_bottom_left_o),
    .pixel_bottom_right_o (pixel_bottom_right_o)
  );

  // Shadow copy of the register file, updated on every write transaction
  logic [7:0]         luma_offset_q;
  logic signed [15:0] luma_gain_q;
  logic signed [15:0] red_cr_gain_q;
  logic signed [15:0] blue_cb_gain_q;
  logic signed [15:0] green_cb_gain_q;
  logic signed [15:0] green_cr_gain_q;

  // Predicted pixel blocks, oldest first
  rgba_block_t pending_pixels[$];

  // Idling controls for the two channels
  bit send_gaps_on;
  bit sink_stalls_on;

  int unsigned fail_count;
  int unsigned blocks_sent;
  int unsigned blocks_checked;
  int unsigned reg_writes;
  int unsigned settings_used;
  int unsigned cycle_count;

  string lane_name [4] = '{"pixel_top_left", "pixel_top_right",
                           "pixel_bottom_left", "pixel_bottom_right"};

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Low 16 bits of a signed product, read back as signed
  function automatic logic signed [15:0] wrap_mul(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
    logic signed [31:0] p;
    p = a * b;
    return p[15:0];
  endfunction

  function automatic logic [7:0] clamp_u8(input logic signed [15:0] v);
    if (v < 0) return 8'd0;
    if (v > 16'sd255) return 8'hFF;
    return v[7:0];
  endfunction

  function automatic rgba_block_t convert_block(input yuv_block_t b);
    logic signed [15:0] cb_c;
    logic signed [15:0] cr_c;
    logic signed [15:0] red_t;
    logic signed [15:0] grn_sum;
    logic signed [15:0] grn_t;
    logic signed [15:0] blu_t;
    logic signed [15:0] y;
    logic [7:0]         a;
    int                 d;
    rgba_block_t        res;
    // Chroma is offset binary around 128
    cb_c    = $signed({8'd0, b.cb}) - 16'sd128;
    cr_c    = $signed({8'd0, b.cr}) - 16'sd128;
    red_t   = wrap_mul(cr_c, red_cr_gain_q) >>> 6;
    grn_sum = wrap_mul(cb_c, green_cb_gain_q) + wrap_mul(cr_c, green_cr_gain_q);
    grn_t   = grn_sum >>> 7;
    blu_t   = wrap_mul(cb_c, blue_cb_gain_q) >>> 6;
    for (int k = 0; k < NumLanes; k++) begin
      // Luma below black level clamps at zero rather than wrapping
      d = int'(b.luma[k]) - int'(luma_offset_q);
      if (d < 0) d = 0;
      y = wrap_mul($signed(d[15:0]), luma_gain_q) >>> 7;
      a = b.has_alpha ? b.alpha[k] : 8'hFF;
      res.pix[k] = {a, clamp_u8(y + blu_t), clamp_u8(y - grn_t), clamp_u8(y + red_t)};
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // lumas and alphas packed as {bottom_right, bottom_left, top_right, top_left}
  function automatic yuv_block_t make_block(input logic [31:0] lumas, input logic [7:0] cb,
                                            input logic [7:0] cr, input logic [31:0] alphas,
                                            input logic has_alpha);
    yuv_block_t b;
    b.luma      = lumas;
    b.cb        = cb;
    b.cr        = cr;
    b.alpha     = alphas;
    b.has_alpha = has_alpha;
    return b;
  endfunction

  // Uniform bytes with extra weight on the rails and on the chroma midpoint
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'(126 + $urandom_range(0, 4));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'(int'($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic yuv_block_t rand_block();
    yuv_block_t b;
    for (int k = 0; k < NumLanes; k++) begin
      b.luma[k]  = rand_byte();
      b.alpha[k] = rand_byte();
    end
    b.cb        = rand_byte();
    b.cr        = rand_byte();
    b.has_alpha = 1'($urandom);
    return b;
  endfunction

  // One register write transaction; only issued while the pipeline is empty
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LUMA_OFFSET:   luma_offset_q   = data[7:0];
      CFG_LUMA_GAIN:     luma_gain_q     = data;
      CFG_RED_CR_GAIN:   red_cr_gain_q   = data;
      CFG_BLUE_CB_GAIN:  blue_cb_gain_q  = data;
      CFG_GREEN_CB_GAIN: green_cb_gain_q = data;
      CFG_GREEN_CR_GAIN: green_cr_gain_q = data;
      default: ;  // unmapped index, dropped by the block
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic load_gains(input logic [15:0] offset_word, input logic [15:0] y_gain,
                            input logic [15:0] r_gain, input logic [15:0] b_gain,
                            input logic [15:0] gcb_gain, input logic [15:0] gcr_gain);
    write_reg(CFG_LUMA_OFFSET, offset_word);
    write_reg(CFG_LUMA_GAIN, y_gain);
    write_reg(CFG_RED_CR_GAIN, r_gain);
    write_reg(CFG_BLUE_CB_GAIN, b_gain);
    write_reg(CFG_GREEN_CB_GAIN, gcb_gain);
    write_reg(CFG_GREEN_CR_GAIN, gcr_gain);
    settings_used++;
  endtask

  // Sends one block; valid stays high after the transaction unless the next
  // call opens a gap or the caller drains.
  task automatic send_block(input yuv_block_t b);
    if (send_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {luma_bottom_right_i, luma_bottom_left_i, luma_top_right_i, luma_top_left_i} <= b.luma;
    chroma_blue_i <= b.cb;
    chroma_red_i  <= b.cr;
    {alpha_bottom_right_i, alpha_bottom_left_i, alpha_top_right_i, alpha_top_left_i} <= b.alpha;
    alpha_present_i <= b.has_alpha;
    do @(posedge clk_i); while (!in_ready_o);
    pending_pixels.push_back(convert_block(b));
    blocks_sent++;
  endtask

  // Drop valid and hold off until every predicted block has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset gains: rails, black level clamp, chroma corners, alpha on and off
  task automatic test_default_settings();
    send_block(make_block(32'h0000_0000, 8'h00, 8'h00, 32'h0000_0000, 1'b0));
    send_block(make_block(32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'h0000_0000, 1'b1));
    send_block(make_block(32'h1110_0F00, 8'h80, 8'h80, 32'hFFFF_FFFF, 1'b1));
    send_block(make_block(32'hFFFF_FFFF, 8'h00, 8'h00, 32'hFF00_FF00, 1'b1));
    send_block(make_block(32'h80FF_4010, 8'hFF, 8'h00, 32'h1234_5678, 1'b1));
    send_block(make_block(32'h10EB_7F01, 8'h00, 8'hFF, 32'h1234_5678, 1'b0));
    send_block(make_block(32'hEB10_EB10, 8'h80, 8'h80, 32'h0000_0000, 1'b0));
    send_block(make_block(32'h5A5A_A5A5, 8'h5A, 8'hA5, 32'hA5A5_5A5A, 1'b1));
    drain();
  endtask

  // Writes to unmapped indexes must leave the gains untouched
  task automatic test_unmapped_index();
    write_reg(CFG_UNMAPPED_LO, 16'($urandom) | 16'h0001);
    write_reg(CFG_UNMAPPED_HI, 16'($urandom) | 16'h8000);
    send_block(make_block(32'hC0A0_6020, 8'h30, 8'hD0, 32'h0102_0304, 1'b1));
    send_block(make_block(32'hFF10_0080, 8'hF0, 8'h10, 32'h0000_0000, 1'b0));
    drain();
  endtask

  // Largest gains so that products and the green sum wrap at 16 bits
  task automatic test_gain_extremes();
    load_gains(16'hFF00, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_block(make_block(32'hFF80_0100, 8'h00, 8'hFF, 32'h0000_0000, 1'b0));
    send_block(make_block(32'hFFFF_FFFF, 8'hFF, 8'h00, 32'hFFFF_FFFF, 1'b1));
    send_block(make_block(32'h0302_0100, 8'h81, 8'h7F, 32'h8040_2010, 1'b1));
    drain();
    load_gains(16'h00FF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_block(make_block(32'hFFFE_0100, 8'h00, 8'h00, 32'h0000_0000, 1'b0));
    send_block(make_block(32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'h7F7F_7F7F, 1'b1));
    send_block(make_block(32'h00FF_00FF, 8'h7F, 8'h81, 32'h0000_0000, 1'b0));
    drain();
    load_gains(16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_block(make_block(32'hFF80_7F01, 8'h00, 8'hFF, 32'h00FF_00FF, 1'b1));
    send_block(make_block(32'h0102_0304, 8'hFF, 8'h00, 32'h0000_0000, 1'b0));
    send_block(make_block(32'h0000_0000, 8'h80, 8'h80, 32'hFFFF_FFFF, 1'b1));
    drain();
  endtask

  // Random register settings, each followed by a stream of random blocks
  task automatic test_random_settings();
    for (int phase = 0; phase < 8; phase++) begin
      load_gains({8'($urandom), rand_byte()}, rand_gain(), rand_gain(), rand_gain(),
                 rand_gain(), rand_gain());
      // Every third phase runs flat out on both sides
      send_gaps_on   = (phase % 3 != 0) && ($urandom_range(0, 3) != 0);
      sink_stalls_on = (phase % 3 != 0) && ($urandom_range(0, 3) != 0);
      repeat (60) send_block(rand_block());
      drain();
    end
  endtask

  // Back to reset gains, no idling on either side
  task automatic test_closing_stream();
    send_gaps_on   = 1'b0;
    sink_stalls_on = 1'b0;
    load_gains({8'h00, LUMA_OFFSET_RST}, LUMA_GAIN_RST, RED_CR_GAIN_RST, BLUE_CB_GAIN_RST,
               GREEN_CB_GAIN_RST, GREEN_CR_GAIN_RST);
    repeat (70) send_block(rand_block());
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_index_i          = CFG_LUMA_OFFSET;
    cfg_data_i           = '0;
    in_valid_i           = 1'b0;
    luma_top_left_i      = '0;
    luma_top_right_i     = '0;
    luma_bottom_left_i   = '0;
    luma_bottom_right_i  = '0;
    chroma_blue_i        = '0;
    chroma_red_i         = '0;
    alpha_top_left_i     = '0;
    alpha_top_right_i    = '0;
    alpha_bottom_left_i  = '0;
    alpha_bottom_right_i = '0;
    alpha_present_i      = 1'b0;
    luma_offset_q        = LUMA_OFFSET_RST;
    luma_gain_q          = LUMA_GAIN_RST;
    red_cr_gain_q        = RED_CR_GAIN_RST;
    blue_cb_gain_q       = BLUE_CB_GAIN_RST;
    green_cb_gain_q      = GREEN_CB_GAIN_RST;
    green_cr_gain_q      = GREEN_CR_GAIN_RST;
    send_gaps_on         = 1'b1;
    sink_stalls_on       = 1'b1;
    settings_used        = 1;  // reset values count as the first setting

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_settings();
    test_unmapped_index();
    test_gain_extremes();
    test_random_settings();
    test_closing_stream();

    // Let anything stray fall out of the pipe before the verdict
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
    if (pending_pixels.size() != 0) begin
      $error("%0d predicted blocks never came out", pending_pixels.size());
      fail_count++;
    end

    $display("Sent %0d blocks, checked %0d, over %0d register settings (%0d writes).",
             blocks_sent, blocks_checked, settings_used, reg_writes);
    $display("Included gain wrap, black level clamp, channel saturation and unmapped writes.");
    if (fail_count == 0) begin
      $display("yuv420_block_to_rgba_top regression: pass");
    end else begin
      $display("yuv420_block_to_rgba_top regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: random back pressure in bursts
  // ---------------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every output transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  rgba_block_t got_pixels;
  rgba_block_t want_pixels;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_pixels.pix = {pixel_bottom_right_o, pixel_bottom_left_o,
                        pixel_top_right_o, pixel_top_left_o};
      if (pending_pixels.size() == 0) begin
        $error("output transaction with no block outstanding: %h", got_pixels.pix);
        fail_count++;
      end else begin
        want_pixels = pending_pixels.pop_front();
        blocks_checked++;
        for (int k = 0; k < NumLanes; k++) begin
          if (got_pixels.pix[k] !== want_pixels.pix[k]) begin
            $error("%s: expected %h, actual %h", lane_name[k], want_pixels.pix[k],
                   got_pixels.pix[k]);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d blocks outstanding", cycle_count,
               pending_pixels.size());
      $display("yuv420_block_to_rgba_top regression: fail");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
